FILE: sv/msc_pkg.sv
// Shared types and constants for the motion segment classifier.
// No dependencies; every other file imports this package.
package msc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned ACC_W  = 16;
  localparam int unsigned THR_W  = 15;
  localparam int unsigned LIM_W  = 4;

  // result queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // configuration register indexes
  localparam logic CFG_IDX_THR = 1'b0;
  localparam logic CFG_IDX_LIM = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = 15'd50;
  localparam logic [LIM_W-1:0] LIM_RESET = 4'd2;

  typedef enum logic [2:0] {
    CLS_STATIC = 3'd0,
    CLS_JERK   = 3'd1,
    CLS_ACCEL  = 3'd2,
    CLS_DECEL  = 3'd3,
    CLS_CONST  = 3'd4
  } seg_class_e;

  typedef struct packed {
    logic             we;
    logic             idx;
    logic [THR_W-1:0] data;
  } cfg_wr_t;

  // one entry per sample that produces results: an optional closed segment
  // (class change) followed by an optional flushed segment (end of stream)
  typedef struct packed {
    logic              chg;
    seg_class_e        old_cls;
    logic [TIME_W-1:0] old_begin;
    logic [TIME_W-1:0] old_end;
    logic              eos;
    seg_class_e        fin_cls;
    logic [TIME_W-1:0] fin_begin;
    logic [TIME_W-1:0] fin_end;
  } seg_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: sv/msc_front.sv
// Front end: config registers, sample history, classification and segment tracking.
// Depends on msc_pkg.
module msc_front #(
  parameter int unsigned WINDOW_SIZE = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  msc_pkg::cfg_wr_t                  cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [msc_pkg::TIME_W-1:0]        time_i,
  input  logic signed [msc_pkg::ACC_W-1:0]  accel_i,
  input  logic                              eos_i,
  input  msc_pkg::q_stat_t                  q_stat_i,
  output logic                              push_o,
  output msc_pkg::seg_entry_t               entry_o
);
  import msc_pkg::*;

  localparam int unsigned HIST_D   = WINDOW_SIZE + 1;
  localparam int unsigned SEEN_MAX = WINDOW_SIZE + 2;
  localparam int unsigned SEEN_W   = $clog2(SEEN_MAX + 1);
  localparam int unsigned REV_W    = $clog2(WINDOW_SIZE);
  localparam int unsigned CMP_W    = (REV_W > LIM_W) ? REV_W : LIM_W;

  logic [THR_W-1:0] thr_q;
  logic [LIM_W-1:0] lim_q;

  logic signed [ACC_W-1:0] hist_q [HIST_D];
  logic [SEEN_W-1:0]       seen_q, seen_d;
  seg_class_e              cur_q, cur_d;
  logic [TIME_W-1:0]       begin_q, begin_d;
  logic [TIME_W-1:0]       prev_q, prev_d;

  logic signed [ACC_W:0] slope [WINDOW_SIZE];
  logic [WINDOW_SIZE-2:0] rev_vec;
  logic [REV_W-1:0]       rev_cnt;
  logic                   jerky, seen_ok, accept, chg;
  logic signed [ACC_W:0]  a_ext, thr_s, neg_thr, mag, step;
  seg_class_e             cls;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      lim_q <= LIM_RESET;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == CFG_IDX_THR) thr_q <= cfg_i.data;
      if (cfg_i.idx == CFG_IDX_LIM) lim_q <= cfg_i.data[LIM_W-1:0];
    end
  end

  // slopes between neighbors, newest first
  for (genvar k = 0; k < WINDOW_SIZE; k++) begin : g_slope
    assign slope[k] = {hist_q[k][ACC_W-1], hist_q[k]}
                    - {hist_q[k+1][ACC_W-1], hist_q[k+1]};
  end

  // strict sign reversal between adjacent slopes; zero never counts
  for (genvar m = 1; m < WINDOW_SIZE; m++) begin : g_rev
    assign rev_vec[m-1] =
      (!slope[m-1][ACC_W] && (|slope[m-1]) && slope[m][ACC_W]) ||
      (slope[m-1][ACC_W] && !slope[m][ACC_W] && (|slope[m]));
  end

  always_comb begin
    rev_cnt = '0;
    for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
      rev_cnt = rev_cnt + REV_W'(rev_vec[i]);
    end
  end

  assign jerky   = CMP_W'(rev_cnt) > CMP_W'(lim_q);
  assign seen_ok = seen_q >= SEEN_W'(WINDOW_SIZE + 1);

  assign a_ext   = {accel_i[ACC_W-1], accel_i};
  assign thr_s   = {2'b00, thr_q};
  assign neg_thr = -thr_s;
  assign mag     = accel_i[ACC_W-1] ? -a_ext : a_ext;
  assign step    = a_ext - {hist_q[0][ACC_W-1], hist_q[0]};

  always_comb begin
    if (mag < thr_s)             cls = CLS_STATIC;
    else if (seen_ok && jerky)   cls = CLS_JERK;
    else if (step > thr_s)       cls = CLS_ACCEL;
    else if (step < neg_thr)     cls = CLS_DECEL;
    else                         cls = CLS_CONST;
  end

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign chg        = (seen_q != '0) && (cls != cur_q);

  always_comb begin
    seen_d  = seen_q;
    cur_d   = cur_q;
    begin_d = begin_q;
    prev_d  = prev_q;
    if (seen_q == '0) begin
      cur_d   = CLS_STATIC;
      begin_d = time_i;
    end else if (chg) begin
      cur_d   = cls;
      begin_d = time_i;
    end

    entry_o.chg       = chg;
    entry_o.old_cls   = cur_q;
    entry_o.old_begin = begin_q;
    entry_o.old_end   = prev_q;
    entry_o.eos       = eos_i;
    entry_o.fin_cls   = cur_d;
    entry_o.fin_begin = begin_d;
    entry_o.fin_end   = time_i;

    if (eos_i) begin
      seen_d  = '0;
      cur_d   = CLS_STATIC;
      begin_d = '0;
      prev_d  = '0;
    end else begin
      if (seen_q < SEEN_W'(SEEN_MAX)) seen_d = seen_q + SEEN_W'(1);
      prev_d = time_i;
    end
  end

  assign push_o = accept && (chg || eos_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      cur_q   <= CLS_STATIC;
      begin_q <= '0;
      prev_q  <= '0;
    end else if (accept) begin
      seen_q  <= seen_d;
      cur_q   <= cur_d;
      begin_q <= begin_d;
      prev_q  <= prev_d;
    end
  end

  // history shift line, no reset: only read once written
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_q[0] <= accel_i;
      for (int i = 1; i < HIST_D; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

`ifndef SYNTHESIS
  a_first_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && seen_q == '0) |-> !entry_o.chg)
    else $error("class change reported on first sample of a stream");
`endif

endmodule

FILE: sv/msc_queue.sv
// Short FIFO of segment entries between the front and the back end.
// Depends on msc_pkg.
module msc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  msc_pkg::seg_entry_t entry_i,
  input  logic                pop_i,
  output msc_pkg::seg_entry_t head_o,
  output msc_pkg::q_stat_t    stat_o
);
  import msc_pkg::*;

  seg_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign stat_o.full  = cnt_q == QCNT_W'(QDEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i)      cnt_d = cnt_q + QCNT_W'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");
`endif

endmodule

FILE: sv/msc_back.sv
// Back end: expands queue entries into one or two results, output register.
// Depends on msc_pkg.
module msc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  msc_pkg::seg_entry_t         head_i,
  input  msc_pkg::q_stat_t            q_stat_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output msc_pkg::seg_class_e         cls_o,
  output logic [msc_pkg::TIME_W-1:0]  start_o,
  output logic [msc_pkg::TIME_W-1:0]  end_o,
  output logic                        last_o,
  output logic                        done_o
);
  import msc_pkg::*;

  logic              valid_q, valid_d;
  logic              phase_q, phase_d;
  seg_class_e        cls_q, cls_d;
  logic [TIME_W-1:0] start_q, start_d, end_q, end_d;
  logic              last_q, last_d, done_q, done_d;
  logic              load, first_piece, two;

  assign load        = !q_stat_i.empty && (!valid_q || out_ready_i);
  assign first_piece = head_i.chg && !phase_q;
  assign two         = head_i.chg && head_i.eos;
  assign pop_o       = load && !(first_piece && two);

  always_comb begin
    if (first_piece) begin
      cls_d   = head_i.old_cls;
      start_d = head_i.old_begin;
      end_d   = head_i.old_end;
      last_d  = !head_i.eos;
      done_d  = 1'b0;
    end else begin
      cls_d   = head_i.fin_cls;
      start_d = head_i.fin_begin;
      end_d   = head_i.fin_end;
      last_d  = 1'b1;
      done_d  = 1'b1;
    end
    phase_d = load ? (first_piece && two) : phase_q;
    valid_d = load ? 1'b1 : (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cls_q   <= cls_d;
      start_q <= start_d;
      end_q   <= end_d;
      last_q  <= last_d;
      done_q  <= done_d;
    end
  end

  assign out_valid_o = valid_q;
  assign cls_o       = cls_q;
  assign start_o     = start_q;
  assign end_o       = end_q;
  assign last_o      = last_q;
  assign done_o      = done_q;

`ifndef SYNTHESIS
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!q_stat_i.empty && head_i.chg && head_i.eos))
    else $error("second result pending without a two-result entry");
`endif

endmodule

FILE: sv/motion_segment_classifier_unit.sv
// Top level of the motion segment classifier: front, queue, back.
// Depends on msc_pkg, msc_front, msc_queue, msc_back.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sample_time, accel; tlast: end_of_stream
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: class, start, end; tlast: run_last;
//                                              tuser: stream_done
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i (always ready)
//
// Cycles: one sample per clock while the queue is not full. Classification is
//   done in the accept cycle; results sit in a 4-entry queue and leave through
//   the output register, one per clock while m_axis_tready is high, so a sample
//   that closes a segment and ends the stream yields two results. Each result
//   is written to the queue and then to the output register before valid rises.
// Reset: asynchronous, active low; clears stream state, queue and output
//   valid, and loads threshold 50 and jerk limit 2. No clearing pass.
// Stalls: s_axis_tready drops only while the queue is full; output
//   back-pressure fills the queue before it reaches the input.
module motion_segment_classifier_unit #(
  parameter int unsigned WINDOW_SIZE = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] sample_time, [47:32] accel
  input  logic        s_axis_tlast,   // end_of_stream
  // segment stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [2:0] class, [34:3] start, [66:35] end, zero pad
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser,   // stream_done
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [14:0] cfg_data_i
);
  import msc_pkg::*;

  cfg_wr_t            cfg_wr;
  q_stat_t            q_stat;
  seg_entry_t         entry, head;
  logic               push, pop;
  seg_class_e         out_cls;
  logic [TIME_W-1:0]  out_start, out_end;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr.we   = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.idx  = cfg_index_i;
  assign cfg_wr.data = cfg_data_i;

  // classification and segment tracking
  msc_front #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .time_i     (s_axis_tdata[31:0]),
    .accel_i    (s_axis_tdata[47:32]),
    .eos_i      (s_axis_tlast),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (entry)
  );

  // decoupling queue
  msc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  // result expansion and output register
  msc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cls_o       (out_cls),
    .start_o     (out_start),
    .end_o       (out_end),
    .last_o      (m_axis_tlast),
    .done_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {5'b00000, out_end, out_start, out_cls};

endmodule

FILE: tb/sv/msc_segment_checker.sv
// Segment checker: watches the sample, segment and register channels of the
// motion segment classifier, predicts every segment and compares it.
// Depends on msc_pkg for the class enum, register indexes and reset values.
module msc_segment_checker #(
  parameter int unsigned WINDOW_SIZE = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [47:0] s_data_i,    // [31:0] sample_time, [47:32] accel
  input  logic        s_last_i,    // end_of_stream
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [71:0] m_data_i,    // [2:0] class, [34:3] start, [66:35] end
  input  logic        m_last_i,    // run_last
  input  logic        m_user_i,    // stream_done
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [14:0] cfg_data_i,
  output int          mismatches_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import msc_pkg::*;

  localparam int unsigned SEEN_MAX = WINDOW_SIZE + 2;

  typedef struct {
    seg_class_e  cls;
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic        last;
    logic        done;
  } seg_result_t;

  seg_result_t segment_exp_q[$];

  // predictor copy of registers and stream state
  logic [14:0]        thr_reg;
  logic [3:0]         lim_reg;
  logic signed [15:0] acc_hist [0:WINDOW_SIZE];
  int unsigned        n_seen;
  seg_class_e         open_cls;
  logic [31:0]        open_begin;
  logic [31:0]        last_time;

  int fail_cnt    = 0;
  int pending_cnt = 0;
  int seg_count   = 0;

  assign mismatches_o = fail_cnt;
  assign pending_o    = pending_cnt;

  function automatic void clear_stream();
    for (int i = 0; i <= WINDOW_SIZE; i++) acc_hist[i] = '0;
    n_seen     = 0;
    open_cls   = CLS_STATIC;
    open_begin = '0;
    last_time  = '0;
  endfunction

  function automatic seg_class_e classify_sample(logic signed [15:0] a);
    int thr, mag, step, later, earlier, flips;
    thr   = int'(thr_reg);
    mag   = (a < 0) ? -int'(a) : int'(a);
    step  = int'(a) - int'(acc_hist[0]);
    flips = 0;
    if (mag < thr) return CLS_STATIC;
    if (n_seen >= WINDOW_SIZE + 1) begin
      for (int m = 1; m < WINDOW_SIZE; m++) begin
        later   = int'(acc_hist[m-1]) - int'(acc_hist[m]);
        earlier = int'(acc_hist[m]) - int'(acc_hist[m+1]);
        if ((later > 0 && earlier < 0) || (later < 0 && earlier > 0)) flips++;
      end
      if (flips > int'(lim_reg)) return CLS_JERK;
    end
    if (step > thr) return CLS_ACCEL;
    if (step < -thr) return CLS_DECEL;
    return CLS_CONST;
  endfunction

  task automatic predict_sample(logic [31:0] t, logic signed [15:0] a, logic eos);
    seg_class_e cls;
    if (n_seen == 0) begin
      open_cls   = CLS_STATIC;
      open_begin = t;
    end else begin
      cls = classify_sample(a);
      if (cls != open_cls) begin
        segment_exp_q.push_back('{open_cls, open_begin, last_time, !eos, 1'b0});
        open_cls   = cls;
        open_begin = t;
      end
    end
    for (int i = WINDOW_SIZE; i > 0; i--) acc_hist[i] = acc_hist[i-1];
    acc_hist[0] = a;
    if (n_seen < SEEN_MAX) n_seen++;
    last_time = t;
    if (eos) begin
      segment_exp_q.push_back('{open_cls, open_begin, t, 1'b1, 1'b1});
      clear_stream();
    end
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    fail_cnt++;
    $display("%0t ns segment %0d %s: got 0x%0h, want 0x%0h",
             $realtime, seg_count, field, got, want);
  endtask

  task automatic check_segment();
    seg_result_t want;
    seg_count++;
    if (segment_exp_q.size() == 0) begin
      report_mismatch("arrived with none expected, class", m_data_i[2:0], '0);
      return;
    end
    want = segment_exp_q.pop_front();
    if (m_data_i[2:0] !== want.cls) report_mismatch("class", m_data_i[2:0], want.cls);
    if (m_data_i[34:3] !== want.seg_start)
      report_mismatch("start", m_data_i[34:3], want.seg_start);
    if (m_data_i[66:35] !== want.seg_end)
      report_mismatch("end", m_data_i[66:35], want.seg_end);
    if (m_last_i !== want.last) report_mismatch("run_last", m_last_i, want.last);
    if (m_user_i !== want.done) report_mismatch("stream_done", m_user_i, want.done);
  endtask

  // Outputs are compared before the same edge's sample is predicted; a
  // segment can never leave in the cycle its sample is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_reg = THR_RESET;
      lim_reg = LIM_RESET;
      clear_stream();
      segment_exp_q.delete();
      pending_cnt = 0;
    end else begin
      if (m_valid_i && m_ready_i) check_segment();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IDX_THR: thr_reg = cfg_data_i;
          CFG_IDX_LIM: lim_reg = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) predict_sample(s_data_i[31:0], s_data_i[47:32], s_last_i);
      pending_cnt = segment_exp_q.size();
    end
  end

endmodule

FILE: tb/sv/motion_segment_classifier_unit_test.sv
// Regression bench for motion_segment_classifier_unit: drives sample streams
// and register writes, throttles the segment side, and reports the verdict.
// Depends on msc_pkg, the block's RTL and msc_segment_checker.
module motion_segment_classifier_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import msc_pkg::*;

  localparam int unsigned WINDOW       = 5;
  localparam int          RESET_CYCLES = 10;
  localparam int          PHASE_ITEMS  = 200;   // 7 phases, about 1400 samples
  localparam int          HOLD_CYCLES  = 150;   // long segment-side hold-off
  localparam int          DRAIN_LIMIT  = 20000;
  localparam int          SETTLE       = 6;     // wait after a drain for samples still in flight
  localparam int          IDLE_PCT     = 27;
  localparam longint      TIMEOUT_NS   = 3_000_000;

  // stream content shapes
  localparam int SHAPE_NOISE  = 0;
  localparam int SHAPE_WALK   = 1;
  localparam int SHAPE_ZIGZAG = 2;
  localparam int SHAPE_RAMP   = 3;
  localparam int SHAPE_NEAR   = 4;

  logic        clk_i  = 1'b0;
  logic        rst_ni;

  logic        s_valid;
  logic        s_ready;
  logic [47:0] s_data;      // [31:0] sample_time, [47:32] accel
  logic        s_last;      // end_of_stream
  logic        m_valid;
  logic        m_ready;
  logic [71:0] m_data;      // [2:0] class, [34:3] start, [66:35] end, zero pad
  logic        m_last;      // run_last
  logic        m_user;      // stream_done
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [14:0] cfg_data;

  int mismatches;
  int pending;

  // shared between the stimulus and the segment-side throttle
  bit no_gaps  = 1'b0;   // both sides run back to back
  bit hold_req = 1'b0;   // ask the throttle for one long hold-off

  int unsigned items_sent = 0;
  int          cur_thr    = int'(THR_RESET);

  always #4 clk_i = ~clk_i;

  motion_segment_classifier_unit #(
    .WINDOW_SIZE (WINDOW)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .m_axis_tuser  (m_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  msc_segment_checker #(
    .WINDOW_SIZE (WINDOW)
  ) seg_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .s_last_i     (s_last),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .m_last_i     (m_last),
    .m_user_i     (m_user),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("motion_segment_classifier_unit regression: fail");
    $finish;
  end

  // Segment-side throttle. Drops tready at random with the idle
  // percentage, never while no_gaps is set. On a hold request it keeps
  // tready low for a long count of its own while samples keep coming, so
  // the result queue fills and s_axis_tready has to fall.
  initial begin
    m_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // One sample request. Before it, unless no_gaps is set, each cycle is
  // idle with the idle probability. tvalid stays high from one request to
  // the next unless an idle cycle is taken, so it is never lowered and
  // raised in the same step.
  task automatic send_sample(logic [31:0] t, logic [15:0] a, logic eos);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= {a, t};
    s_last  <= eos;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop offering samples, wait for every predicted segment, then let the
  // pipeline settle: a sample with no segment may still be in flight.
  task automatic drain_segments();
    int guard;
    guard = 0;
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Both register writes back to back; valid drops once at the end.
  task automatic configure(logic [14:0] thr, logic [3:0] lim);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_THR;
    cfg_data  <= thr;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_index <= CFG_IDX_LIM;
    cfg_data  <= {11'd0, lim};
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    cur_thr = int'(thr);
  endtask

  // One stream of samples with a content shape:
  //   noise: any accel, any time
  //   walk: random walk in steps scaled to the threshold
  //   zigzag: large alternating steps, now and then a flat step, to
  //     reach the jerk class once the window is full
  //   ramp: steps beyond the threshold in one direction
  //   near static: magnitudes around the threshold
  // An open stream (no end_of_stream) leaves its state to the next one.
  task automatic send_stream(int len, int shape, bit closed);
    logic [31:0] t;
    int          a, span, base, amp, dir;
    span = (cur_thr < 8) ? 8 : cur_thr;
    t    = $urandom;
    a    = int'($urandom_range(0, 2 * span)) - span;
    base = int'($urandom_range(0, span)) - span / 2;
    amp  = span + int'($urandom_range(1, span));
    dir  = ($urandom_range(0, 1) != 0) ? 1 : -1;
    for (int k = 0; k < len; k++) begin
      case (shape)
        SHAPE_NOISE: begin
          a = int'($urandom_range(0, 65535)) - 32768;
          t = $urandom;
        end
        SHAPE_WALK: a = a + int'($urandom_range(0, 6 * span)) - 3 * span;
        SHAPE_ZIGZAG: begin
          if ($urandom_range(0, 9) != 0) a = (k % 2 != 0) ? base + amp : base - amp;
        end
        SHAPE_RAMP: a = a + dir * (span + int'($urandom_range(1, span)));
        default: a = int'($urandom_range(0, 4 * span)) - 2 * span;
      endcase
      a = clamp16(a);
      if (shape != SHAPE_NOISE) t = t + $urandom_range(0, 2000);
      send_sample(t, a[15:0], closed && (k == len - 1));
    end
  endtask

  task automatic random_stream();
    int pick, shape, len;
    pick  = $urandom_range(0, 99);
    shape = (pick < 10) ? SHAPE_NOISE : (pick < 30) ? SHAPE_WALK :
            (pick < 60) ? SHAPE_ZIGZAG : (pick < 80) ? SHAPE_RAMP : SHAPE_NEAR;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(6, 20);
    send_stream(len, shape, $urandom_range(0, 9) != 0);
  endtask

  // Stimulus: reset, directed streams on reset settings, then random
  // phases over a sweep of threshold and jerk-limit settings.
  initial begin
    logic [14:0] thr_set [7];
    logic [3:0]  lim_set [7];
    int unsigned phase_base;

    rst_ni    = 1'b0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_last    = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IDX_THR;
    cfg_data  = '0;

    thr_set = '{15'd50, 15'd0, 15'h7FFF, 15'd1, 15'($urandom_range(0, 32767)),
                15'd300, 15'd2000};
    lim_set = '{4'd2, 4'd0, 4'd15, 4'd1, 4'($urandom_range(0, 15)), 4'd3, 4'd4};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone sample: opens and flushes its own segment at once
    send_sample(32'd100, 16'sd0, 1'b1);

    // full-scale swings: accelerating, decelerating with the widest step,
    // constant at the most negative value, back to static
    send_sample(32'd0, 16'sd0, 1'b0);
    send_sample(32'd1, 16'sd32767, 1'b0);
    send_sample(32'd2, -16'sd32768, 1'b0);
    send_sample(32'd3, -16'sd32768, 1'b0);
    send_sample(32'd4, 16'sd0, 1'b0);
    // zigzag past the window fill: jerk once enough reversals are seen
    send_sample(32'd5, 16'sd200, 1'b0);
    send_sample(32'd6, -16'sd200, 1'b0);
    send_sample(32'd7, 16'sd300, 1'b0);
    send_sample(32'd8, -16'sd300, 1'b0);
    send_sample(32'd9, 16'sd300, 1'b0);
    send_sample(32'd10, -16'sd300, 1'b0);
    send_sample(32'd11, 16'sd300, 1'b0);
    send_sample(32'd12, -16'sd300, 1'b0);
    send_sample(32'hFFFF_FFFF, -16'sd300, 1'b1);

    // threshold edges: magnitude equal to it is not static, step equal to
    // it is constant, one more is accelerating
    send_sample(32'hFFFF_FFF0, 16'sd50, 1'b0);
    send_sample(32'hFFFF_FFF2, 16'sd49, 1'b0);
    send_sample(32'hFFFF_FFF4, -16'sd50, 1'b0);
    send_sample(32'hFFFF_FFF6, 16'sd0, 1'b0);
    send_sample(32'hFFFF_FFF8, 16'sd50, 1'b0);
    send_sample(32'hFFFF_FFFA, 16'sd100, 1'b0);
    send_sample(32'hFFFF_FFFC, 16'sd151, 1'b0);
    send_sample(32'h0000_0002, 16'sd151, 1'b1);

    for (int p = 0; p < 7; p++) begin
      drain_segments();
      configure(thr_set[p], lim_set[p]);
      no_gaps = (p == 5);
      // fill the block against a stalled segment side in two phases
      if (p == 1 || p == 4) hold_req = 1'b1;
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS) random_stream();
    end
    no_gaps = 1'b0;

    drain_segments();
    if (pending != 0) $display("%0d expected segments never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("motion_segment_classifier_unit regression: pass");
    end else begin
      $display("motion_segment_classifier_unit regression: fail");
    end
    $finish;
  end

endmodule
